[design/rol_pkg.sv]
// rol_pkg: shared types and constants for the recency-ordered id list
// used by rol_ctrl, rol_dp and recency_ordered_id_list_top; no dependencies
package rol_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int ID_W      = 32;
	localparam int OCC_W     = 6;
	localparam int RES_W     = 8;

	// operation carried in the input tuser
	typedef enum logic {
		OP_TOUCH  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic srch_step;
		logic shift_start;
		logic shift_from_zero;
		logic shift_step;
		logic put;
		logic append;
		logic set_evict;
		logic out_load;
	} rol_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic srch_done;
		logic shift_done;
		logic hit;
		logic hit_last;
		logic full;
		logic lookup;
		logic out_busy;
	} rol_stat_t;

endpackage

[design/rol_ctrl.sv]
// rol_ctrl: sequencer for search, shift, append and result hand-off
// depends on rol_pkg for the command and status structs
module rol_ctrl import rol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rol_stat_t st,
	output rol_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_DECIDE,
		S_SHIFT,
		S_PUT,
		S_FIN
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (st.srch_done) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (st.lookup) begin
						state_q <= S_FIN;
					end else if (st.hit) begin
						state_q <= st.hit_last ? S_FIN : S_SHIFT;
					end else if (!st.full) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (st.shift_done) state_q <= S_PUT;
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!st.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_SRCH:   cmd.srch_step = 1'b1;
			S_DECIDE: begin
				if (!st.lookup) begin
					if (st.hit) begin
						cmd.shift_start = !st.hit_last;
					end else if (!st.full) begin
						cmd.append = 1'b1;
					end else begin
						cmd.shift_start     = 1'b1;
						cmd.shift_from_zero = 1'b1;
						cmd.set_evict       = 1'b1;
					end
				end
			end
			S_SHIFT:  cmd.shift_step = 1'b1;
			S_PUT:    cmd.put = 1'b1;
			S_FIN:    cmd.out_load = !st.out_busy;
			default:  cmd = '0;
		endcase
	end

endmodule

[design/rol_dp.sv]
// rol_dp: entry memory, scan pointer, compare, count and result register
// depends on rol_pkg for widths, op codes and the command and status structs
module rol_dp import rol_pkg::*; #(
	parameter  int DEPTH = DEPTH_DEF,
	localparam int AW    = $clog2(DEPTH),
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_op,
	input  logic [ID_W-1:0]  in_ident,
	input  rol_cmd_t         cmd,
	output rol_stat_t        st,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] out_data
);

	logic [ID_W-1:0] mem [DEPTH];

	op_t              op_q;
	logic [ID_W-1:0]  ident_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    last_q;
	logic             hit_q;
	logic             evict_q;
	logic             pend_s1;
	logic [AW-1:0]    pend_idx_s1;
	logic [ID_W-1:0]  rd_data_s1;
	logic             out_vld_q;
	logic [RES_W-1:0] out_data_q;

	logic [CW-1:0]    count_m1;
	logic             match;
	logic             rd_en;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [ID_W-1:0]  wr_data;
	logic [AW-1:0]    shift_from;

	assign count_m1   = count_q - CW'(1);
	assign match      = cmd.srch_step && pend_s1 && (rd_data_s1 == ident_q);
	assign shift_from = cmd.shift_from_zero ? '0 : pos_q;

	// one read per cycle during search and shift
	assign rd_en = (cmd.srch_step && (ptr_q < count_q) && !match) ||
	               (cmd.shift_step && (ptr_q <= CW'(last_q)));

	// write port: new id at the tail, append, or shift an entry down one place
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = last_q;
		wr_data = ident_q;
		if (cmd.put) begin
			wr_en = 1'b1;
		end else if (cmd.append) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
		end else if (cmd.shift_step && pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = pend_idx_s1;
			wr_data = rd_data_s1;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= mem[ptr_q[AW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.shift_start) begin
				pend_s1 <= 1'b0;
			end else if (cmd.srch_step || cmd.shift_step) begin
				pend_s1 <= rd_en;
			end
			if (cmd.append) count_q <= count_q + CW'(1);
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// item and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(in_op);
			ident_q <= in_ident;
			ptr_q   <= '0;
			hit_q   <= 1'b0;
			evict_q <= 1'b0;
		end
		if (rd_en) begin
			ptr_q       <= ptr_q + CW'(1);
			pend_idx_s1 <= cmd.shift_step ? AW'(ptr_q - CW'(1)) : ptr_q[AW-1:0];
		end
		if (match) begin
			hit_q <= 1'b1;
			pos_q <= pend_idx_s1;
		end
		if (cmd.shift_start) begin
			ptr_q  <= CW'(shift_from) + CW'(1);
			last_q <= count_m1[AW-1:0];
		end
		if (cmd.set_evict) evict_q <= 1'b1;
		if (cmd.out_load) out_data_q <= {OCC_W'(count_q), evict_q, hit_q};
	end

	// status back to the controller
	always_comb begin
		st.srch_done  = match || (!pend_s1 && (ptr_q >= count_q));
		st.shift_done = !pend_s1 && (ptr_q > CW'(last_q));
		st.hit        = hit_q;
		st.hit_last   = (CW'(pos_q) == count_m1);
		st.full       = (count_q == CW'(DEPTH));
		st.lookup     = (op_q == OP_LOOKUP);
		st.out_busy   = out_vld_q && !out_ready;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

endmodule

[design/recency_ordered_id_list_top.sv]
// recency_ordered_id_list_top: oldest-to-newest id list with touch and lookup
// items are taken one at a time; a lookup, a refresh or an append scans the valid entries,
// and entries shift down when a refresh or an eviction needs it
// the entry memory is scanned with one entry read per cycle in search and shift
// async reset clears the count and the handshake state; entries are not cleared
// depends on rol_pkg, rol_ctrl and rol_dp
module recency_ordered_id_list_top import rol_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ID_W-1:0]  s_tdata,  // [31:0] ident
	input  logic             s_tuser,  // [0] op
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [RES_W-1:0] m_tdata   // [0] hit, [1] evicted, [7:2] occupancy
);

	rol_cmd_t  cmd;
	rol_stat_t st;

	// sequencer
	rol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// entry store and result register
	rol_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_tuser),
		.in_ident  (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

[tb/recency_list_checker.sv]
`timescale 1ns / 100ps
// recency_list_checker: watches both streams of the recency-ordered id list,
// keeps its own copy of the list and checks every result in order; needs rol_pkg
module recency_list_checker import rol_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [ID_W-1:0]  s_tdata,  // [31:0] ident
	input  logic             s_tuser,  // [0] op
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [RES_W-1:0] m_tdata,  // [0] hit, [1] evicted, [7:2] occupancy
	output int               fail_count,
	output int               outstanding,
	output int               checked_count,
	output int               hit_count,
	output int               evict_count
);

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [OCC_W-1:0] occupancy;
	} list_result_t;

	// shadow list, oldest at index 0
	logic [ID_W-1:0] ids [DEPTH];
	int              id_count;
	list_result_t    expected_results [$];

	// apply one touch or lookup to the shadow list and return its result
	function automatic list_result_t update_recency(input op_t op, input logic [ID_W-1:0] ident);
		int           pos;
		list_result_t res;
		pos = -1;
		for (int i = 0; i < id_count; i++)
			if (pos < 0 && ids[i] == ident)
				pos = i;
		res.hit     = (pos >= 0);
		res.evicted = 1'b0;
		if (op == OP_TOUCH) begin
			if (pos >= 0) begin
				// refresh: close the gap and put the id at the newest slot
				for (int i = pos; i < id_count - 1; i++)
					ids[i] = ids[i + 1];
				ids[id_count - 1] = ident;
			end else if (id_count < DEPTH) begin
				ids[id_count] = ident;
				id_count++;
			end else begin
				// full: drop the oldest entry
				for (int i = 0; i < DEPTH - 1; i++)
					ids[i] = ids[i + 1];
				ids[DEPTH - 1] = ident;
				res.evicted    = 1'b1;
			end
		end
		res.occupancy = OCC_W'(id_count);
		return res;
	endfunction

	// predict on input items, compare on output items
	always @(posedge clk or negedge arst_n) begin
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			id_count      = 0;
			expected_results.delete();
			fail_count    = 0;
			outstanding   = 0;
			checked_count = 0;
			hit_count     = 0;
			evict_count   = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(update_recency(op_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				got.hit       = m_tdata[0];
				got.evicted   = m_tdata[1];
				got.occupancy = m_tdata[7:2];
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with nothing pending: hit=%0d evicted=%0d occupancy=%0d",
							$realtime, got.hit, got.evicted, got.occupancy);
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (want.hit)
						hit_count++;
					if (want.evicted)
						evict_count++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: result %0d mismatch: expected hit=%0d evicted=%0d occupancy=%0d",
								$realtime, checked_count, want.hit, want.evicted, want.occupancy);
							$display("%0t: result %0d mismatch: got hit=%0d evicted=%0d occupancy=%0d",
								$realtime, checked_count, got.hit, got.evicted, got.occupancy);
						end
					end
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

[tb/tb_recency_ordered_id_list_top.sv]
`timescale 1ns / 100ps
// tb_recency_ordered_id_list_top: stimulus and verdict for the recency-ordered id list
// depends on rol_pkg, recency_ordered_id_list_top and recency_list_checker
module tb_recency_ordered_id_list_top;
	import rol_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 250;
	localparam int DRAIN_LIMIT   = 20000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [ID_W-1:0]  s_tdata;  // [31:0] ident
	logic             s_tuser;  // [0] op
	logic             m_tvalid;
	logic             m_tready;
	logic [RES_W-1:0] m_tdata;  // [0] hit, [1] evicted, [7:2] occupancy

	int fail_count;
	int outstanding;
	int checked_count;
	int hit_count;
	int evict_count;
	int cycle_count;
	bit no_idle;

	recency_ordered_id_list_top #(.DEPTH(DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	recency_list_checker #(.DEPTH(DEPTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.hit_count     (hit_count),
		.evict_count   (evict_count)
	);

	// clock and reset
	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_recency_ordered_id_list_top: errors");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offer one item and wait until it is taken; valid stays high for back-to-back items
	task automatic offer_item(input op_t op, input logic [ID_W-1:0] ident);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ident;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver: random stalls plus one long hold-off while the sender keeps going
	initial begin
		int rounds;
		int len;
		m_tready = 1'b0;
		rounds   = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			rounds++;
			if (rounds == 150) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			len = idle_cycles();
			if (len > 0) begin
				m_tready <= 1'b0;
				repeat (len) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		logic [ID_W-1:0] id_pool [64];
		int              pool_sizes [RANDOM_PHASES];
		int              pool_size;
		int              waited;
		bit              cyclic;
		op_t             op;
		logic [ID_W-1:0] ident;

		pool_sizes = '{3, 16, 31, 32, 33, 40, 64, 48};
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_TOUCH;
		no_idle  = 1'b0;
		wait (arst_n);
		@(posedge clk);

		// directed: empty list, bit extremes, refresh of newest and of a middle entry
		offer_item(OP_LOOKUP, 32'h0000_0000);
		offer_item(OP_TOUCH,  32'h0000_0000);
		offer_item(OP_TOUCH,  32'hFFFF_FFFF);
		offer_item(OP_LOOKUP, 32'hFFFF_FFFF);
		offer_item(OP_TOUCH,  32'hFFFF_FFFF);
		offer_item(OP_TOUCH,  32'h0000_0000);
		offer_item(OP_LOOKUP, 32'h0000_0000);
		offer_item(OP_TOUCH,  32'h5555_5555);
		offer_item(OP_TOUCH,  32'hAAAA_AAAA);
		offer_item(OP_TOUCH,  32'h0000_0001);
		offer_item(OP_TOUCH,  32'h8000_0000);
		offer_item(OP_TOUCH,  32'hFFFF_FFFF);
		offer_item(OP_LOOKUP, 32'h1234_5678);
		offer_item(OP_TOUCH,  32'h5555_5555);
		offer_item(OP_LOOKUP, 32'hAAAA_AAAA);
		offer_item(OP_TOUCH,  32'h8000_0000);
		offer_item(OP_LOOKUP, 32'h7FFF_FFFF);

		// random phases over pools smaller and larger than the list
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pool_size = pool_sizes[ph];
			for (int i = 0; i < 64; i++)
				id_pool[i] = $urandom;
			if ($urandom_range(0, 1))
				id_pool[0] = '0;
			if ($urandom_range(0, 1))
				id_pool[1] = '1;
			cyclic  = ($urandom_range(0, 2) == 0);
			no_idle = (ph % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 99) < 30) ? OP_LOOKUP : OP_TOUCH;
				if ($urandom_range(0, 99) < 12)
					ident = $urandom;
				else if (cyclic)
					ident = id_pool[n % pool_size];
				else
					ident = id_pool[$urandom_range(0, pool_size - 1)];
				offer_item(op, ident);
			end
		end
		s_tvalid <= 1'b0;
		no_idle  = 1'b0;

		// drain, then allow for the longest scan of the list
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (3 * DEPTH + 10) @(posedge clk);

		$display("checked %0d results: %0d hits, %0d evictions, %0d random phases",
			checked_count, hit_count, evict_count, RANDOM_PHASES);
		$display("pools of 3 to 64 ids, one output hold-off of %0d cycles", HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_recency_ordered_id_list_top: clean");
		else
			$display("tb_recency_ordered_id_list_top: errors");
		$finish;
	end

endmodule
